// ----- design/lmsb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmsb_pkg
// Shared types and constants of the level meter scale and ballistics block.
// ----------------------------------------------------------------------------
package lmsb_pkg;

   localparam int MAX_MARKS_DEFAULT = 5;
   localparam int DB_W              = 16;
   localparam int FRAC_W            = 16;
   localparam int CSR_DATA_W        = 32;
   localparam int CSR_INDEX_W       = 3;
   localparam int COUNT_W           = 3;
   localparam int DIV_STEPS         = 16;

   localparam logic [FRAC_W-1:0]      FULL_SCALE  = 16'd32768;
   localparam logic signed [DB_W-1:0] FLOOR_RESET = -16'sd15360;
   localparam logic signed [DB_W-1:0] CEIL_RESET  = 16'sd0;

   // fall step is ceil(4 * gap / 25) = floor((4 * gap + 24) / 25),
   // done as a multiply by the reciprocal 2^23 / 25 rounded up
   localparam int                FALL_SHIFT = 23;
   localparam int                DROP_W     = 14;
   localparam logic [18:0]       FALL_RECIP = 19'd335545;
   localparam logic [17:0]       FALL_BIAS  = 18'd24;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MARK_COUNT = 3'd0,
      CSR_MARK_ZERO  = 3'd1,
      CSR_MARK_ONE   = 3'd2,
      CSR_MARK_TWO   = 3'd3,
      CSR_MARK_THREE = 3'd4,
      CSR_MARK_FOUR  = 3'd5,
      CSR_FLOOR_DB   = 3'd6,
      CSR_CEILING_DB = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_LAST,
      ST_SEARCH,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV,
      ST_FIX,
      ST_FALL,
      ST_DROP,
      ST_LOAD
   } state_type;

   // mark fractions above full scale read as full scale
   function automatic logic [FRAC_W-1:0] frac_clamp(input logic [FRAC_W-1:0] f);
      logic [FRAC_W-1:0] r;
      r = (f > FULL_SCALE) ? FULL_SCALE : f;
      return r;
   endfunction

endpackage

// ----- design/lmsb_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmsb request and response channels
// Valid/ready channels carrying one level reading in and one meter result out.
// ----------------------------------------------------------------------------
interface lmsb_req_if
   import lmsb_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic signed [DB_W-1:0] level_db;

   modport source (output valid, output level_db, input ready);
   modport sink   (input valid, input level_db, output ready);
endinterface

interface lmsb_rsp_if
   import lmsb_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [FRAC_W-1:0] target_fraction;
   logic [FRAC_W-1:0] shown_fraction;

   modport source (output valid, output target_fraction, output shown_fraction, input ready);
   modport sink   (input valid, input target_fraction, input shown_fraction, output ready);
endinterface

// ----- design/lmsb_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmsb_divider
// Restoring divider, one quotient bit per cycle. The upper half of the
// dividend must be below the divisor so the quotient fits in 16 bits.
// ----------------------------------------------------------------------------
module lmsb_divider
   import lmsb_pkg::*;
   (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [2*FRAC_W-1:0]   num,
   input  logic [FRAC_W-1:0]     den,
   output logic                  done,
   output logic [FRAC_W-1:0]     quot,
   output logic [FRAC_W-1:0]     rem
   );

   localparam int CNT_W = $clog2(DIV_STEPS);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [FRAC_W-1:0]  rem_ff, rem_in;
   logic [FRAC_W-1:0]  low_ff, low_in;
   logic [FRAC_W-1:0]  den_ff, den_in;
   logic [FRAC_W:0]    trial;
   logic [FRAC_W:0]    diff;
   logic               fits;

   always_comb begin
      trial   = {rem_ff, low_ff[FRAC_W-1]};
      diff    = trial - {1'b0, den_ff};
      fits    = (trial >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = num[2*FRAC_W-1:FRAC_W];
         low_in  = num[FRAC_W-1:0];
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = fits ? diff[FRAC_W-1:0] : trial[FRAC_W-1:0];
         low_in = {low_ff[FRAC_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = low_ff;
   assign rem  = rem_ff;

endmodule

// ----- design/level_meter_scale_ballistics_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// level_meter_scale_ballistics_core
// Maps a dB reading onto a meter scale and applies peak-hold fall ballistics.
// ----------------------------------------------------------------------------
// Takes one beat at a time and drops ready until its result is in the output
// register. A reading that clamps to an end of the scale passes the start,
// last-mark (on a clamp to the last mark), fall, drop (when the bar falls) and
// load states. One that needs a division walks the marks (one mark per cycle)
// and takes one multiply, or on the straight ratio goes directly to the 16
// steps of the shared restoring divider; then comes the fall step on the same
// multiplier. The output register holds a finished result while the next beat
// is taken. Write the configuration registers only while no reading is in flight.
module level_meter_scale_ballistics_core
   import lmsb_pkg::*;
   #(
   parameter int MAX_MARKS = MAX_MARKS_DEFAULT
   )
   (
   input  logic                    clock,
   input  logic                    reset,
   lmsb_req_if.sink                req_bus,
   lmsb_rsp_if.source              rsp_bus,
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
   );

   localparam int MIDX_W = $clog2(MAX_MARKS);
   localparam int MUL_A_W = 18;
   localparam int MUL_B_W = 19;
   localparam int PROD_W = MUL_A_W + MUL_B_W;

   // configuration
   logic [COUNT_W-1:0]       mark_count_ff;
   logic [CSR_DATA_W-1:0]    marks_ff [MAX_MARKS];
   logic signed [DB_W-1:0]   floor_ff;
   logic signed [DB_W-1:0]   ceil_ff;

   // sequencer and datapath
   state_type                state_ff, state_in;
   logic signed [DB_W-1:0]   db_ff, db_in;
   logic [MIDX_W-1:0]        idx_ff, idx_in;
   logic signed [DB_W-1:0]   prev_db_ff, prev_db_in;
   logic [FRAC_W-1:0]        prev_frac_ff, prev_frac_in;
   logic [FRAC_W-1:0]        target_ff, target_in;
   logic [FRAC_W-1:0]        shown_ff, shown_in;
   logic [FRAC_W-1:0]        base_ff, base_in;
   logic                     neg_ff, neg_in;
   logic [FRAC_W-1:0]        den_ff, den_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [FRAC_W-1:0]        rsp_target_ff, rsp_target_in;
   logic [FRAC_W-1:0]        rsp_shown_ff, rsp_shown_in;

   logic [COUNT_W-1:0]       count_eff;
   logic                     straight;
   logic [MIDX_W-1:0]        last_idx;
   logic [MIDX_W-1:0]        rd_idx;
   logic [CSR_DATA_W-1:0]    mark_rd;
   logic signed [DB_W-1:0]   rd_db;
   logic [FRAC_W-1:0]        rd_frac;
   logic                     range_empty;
   logic signed [DB_W:0]     lin_diff;
   logic signed [DB_W:0]     seg_t;
   logic signed [DB_W:0]     seg_den;
   logic signed [FRAC_W:0]   seg_d;
   logic [FRAC_W-1:0]        seg_mag;
   logic [MUL_A_W-1:0]       mul_a;
   logic [MUL_B_W-1:0]       mul_b;
   logic [PROD_W-1:0]        mul_p;
   logic [FRAC_W-1:0]        gap;
   logic [MUL_A_W-1:0]       fall_x;
   logic [DROP_W-1:0]        drop;
   logic [FRAC_W:0]          fix_val;
   logic                     div_start;
   logic                     div_done;
   logic [FRAC_W-1:0]        div_quot;
   logic [FRAC_W-1:0]        div_rem;
   logic                     load_ok;
   logic [CSR_INDEX_W-1:0]   mark_slot;
   logic                     mark_hit;

   // ---------------------------------------------------------------- csr
   always_comb begin
      mark_slot = csr_index - CSR_MARK_ZERO;
      mark_hit  = (csr_index inside {[CSR_MARK_ZERO:CSR_MARK_FOUR]}) &&
                  (int'(mark_slot) < MAX_MARKS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_count_ff <= '0;
         floor_ff      <= FLOOR_RESET;
         ceil_ff       <= CEIL_RESET;
         for (int i = 0; i < MAX_MARKS; i++) begin
            marks_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_MARK_COUNT: mark_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_FLOOR_DB:   floor_ff      <= csr_wdata[DB_W-1:0];
            CSR_CEILING_DB: ceil_ff       <= csr_wdata[DB_W-1:0];
            default: begin
               for (int i = 0; i < MAX_MARKS; i++) begin
                  if (mark_hit && (int'(mark_slot) == i)) begin
                     marks_ff[i] <= csr_wdata;
                  end
               end
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- shared parts
   always_comb begin
      count_eff   = (int'(mark_count_ff) > MAX_MARKS) ? COUNT_W'(MAX_MARKS) : mark_count_ff;
      straight    = (count_eff < COUNT_W'(2));
      last_idx    = MIDX_W'(count_eff - COUNT_W'(1));
      case (state_ff)
         ST_START: rd_idx = '0;
         ST_LAST:  rd_idx = last_idx;
         default:  rd_idx = idx_ff;
      endcase
      mark_rd     = marks_ff[rd_idx];
      rd_db       = $signed(mark_rd[CSR_DATA_W-1:FRAC_W]);
      rd_frac     = frac_clamp(mark_rd[FRAC_W-1:0]);
      range_empty = (ceil_ff <= floor_ff);
      lin_diff    = {db_ff[DB_W-1], db_ff} - {floor_ff[DB_W-1], floor_ff};
      seg_t       = {db_ff[DB_W-1], db_ff} - {prev_db_ff[DB_W-1], prev_db_ff};
      seg_den     = {rd_db[DB_W-1], rd_db} - {prev_db_ff[DB_W-1], prev_db_ff};
      seg_d       = $signed({1'b0, rd_frac}) - $signed({1'b0, prev_frac_ff});
      seg_mag     = seg_d[FRAC_W] ? FRAC_W'(-seg_d) : seg_d[FRAC_W-1:0];
      gap         = shown_ff - target_ff;
      fall_x      = {gap, 2'b00} + FALL_BIAS;
      drop        = prod_ff[FALL_SHIFT +: DROP_W];
      // round toward minus infinity on a falling segment
      fix_val     = neg_ff ?
                    ({1'b0, base_ff} - {1'b0, div_quot} - (FRAC_W+1)'(div_rem != '0)) :
                    ({1'b0, base_ff} + {1'b0, div_quot});
      case (state_ff)
         ST_MUL: begin
            mul_a = MUL_A_W'(seg_t[DB_W-1:0]);
            mul_b = MUL_B_W'(seg_mag);
         end
         ST_FALL: begin
            mul_a = fall_x;
            mul_b = FALL_RECIP;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p       = mul_a * mul_b;
      div_start   = (state_ff == ST_DIV_GO);
      load_ok     = !rsp_valid_ff || rsp_bus.ready;
   end

   lmsb_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (prod_ff[2*FRAC_W-1:0]),
      .den   (den_ff),
      .done  (div_done),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) state_in = ST_START;
         end
         ST_START: begin
            if (straight) begin
               if (range_empty || db_ff <= floor_ff || db_ff >= ceil_ff) begin
                  state_in = ST_FALL;
               end else begin
                  state_in = ST_DIV_GO;
               end
            end else if (db_ff <= rd_db) begin
               state_in = ST_FALL;
            end else begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            state_in = (db_ff >= rd_db) ? ST_FALL : ST_SEARCH;
         end
         ST_SEARCH: begin
            if (db_ff <= rd_db) state_in = ST_MUL;
         end
         ST_MUL:    state_in = ST_DIV_GO;
         ST_DIV_GO: state_in = ST_DIV;
         ST_DIV: begin
            if (div_done) state_in = ST_FIX;
         end
         ST_FIX:    state_in = ST_FALL;
         ST_FALL:   state_in = (target_ff < shown_ff) ? ST_DROP : ST_LOAD;
         ST_DROP:   state_in = ST_LOAD;
         ST_LOAD: begin
            if (load_ok) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      db_in         = db_ff;
      idx_in        = idx_ff;
      prev_db_in    = prev_db_ff;
      prev_frac_in  = prev_frac_ff;
      target_in     = target_ff;
      shown_in      = shown_ff;
      base_in       = base_ff;
      neg_in        = neg_ff;
      den_in        = den_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_target_in = rsp_target_ff;
      rsp_shown_in  = rsp_shown_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) db_in = req_bus.level_db;
         end
         ST_START: begin
            if (straight) begin
               if (range_empty || db_ff <= floor_ff) begin
                  target_in = '0;
               end else if (db_ff >= ceil_ff) begin
                  target_in = FULL_SCALE;
               end
               prod_in = PROD_W'({lin_diff[DB_W-1:0], 15'b0});
               den_in  = FRAC_W'(ceil_ff - floor_ff);
               base_in = '0;
               neg_in  = 1'b0;
            end else begin
               target_in    = rd_frac;
               prev_db_in   = rd_db;
               prev_frac_in = rd_frac;
            end
         end
         ST_LAST: begin
            target_in = rd_frac;
            idx_in    = MIDX_W'(1);
         end
         ST_SEARCH: begin
            if (!(db_ff <= rd_db)) begin
               prev_db_in   = rd_db;
               prev_frac_in = rd_frac;
               idx_in       = idx_ff + 1'b1;
            end
         end
         ST_MUL: begin
            prod_in = mul_p;
            den_in  = seg_den[DB_W-1:0];
            base_in = prev_frac_ff;
            neg_in  = seg_d[FRAC_W];
         end
         ST_FIX: begin
            target_in = fix_val[FRAC_W-1:0];
         end
         ST_FALL: begin
            if (target_ff > shown_ff) shown_in = target_ff;
            prod_in = mul_p;
         end
         ST_DROP: begin
            shown_in = shown_ff - FRAC_W'(drop);
         end
         ST_LOAD: begin
            if (load_ok) begin
               rsp_valid_in  = 1'b1;
               rsp_target_in = target_ff;
               rsp_shown_in  = shown_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         shown_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         shown_ff     <= shown_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      db_ff         <= db_in;
      idx_ff        <= idx_in;
      prev_db_ff    <= prev_db_in;
      prev_frac_ff  <= prev_frac_in;
      target_ff     <= target_in;
      base_ff       <= base_in;
      neg_ff        <= neg_in;
      den_ff        <= den_in;
      prod_ff       <= prod_in;
      rsp_target_ff <= rsp_target_in;
      rsp_shown_ff  <= rsp_shown_in;
   end

   assign req_bus.ready           = (state_ff == ST_IDLE);
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.target_fraction = rsp_target_ff;
   assign rsp_bus.shown_fraction  = rsp_shown_ff;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for level_meter_scale_ballistics_core. Drives dB readings
// under straight-ratio and scale-mark settings and predicts the bar target
// and the fall ballistics of every beat. Each response beat is checked in
// order against the prediction while both channels idle at random.
// ----------------------------------------------------------------------------
module tb
   import lmsb_pkg::*;
   ();

   localparam int NUM_MARKS      = 5;
   localparam int FULL_BAR       = 32768;
   localparam int FALL_NUM       = 4;
   localparam int FALL_DEN       = 25;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int MAX_REPORTS    = 10;
   localparam int RATIO_PHASES   = 6;
   localparam int MARK_PHASES    = 13;
   localparam int PHASE_BEATS    = 80;

   typedef struct packed {
      logic [FRAC_W-1:0] target;
      logic [FRAC_W-1:0] shown;
   } meter_reading_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   lmsb_req_if req_bus ();
   lmsb_rsp_if rsp_bus ();

   level_meter_scale_ballistics_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow copy of the meter settings and display state
   logic [COUNT_W-1:0]     mark_total;
   logic [CSR_DATA_W-1:0]  mark_word [NUM_MARKS];
   logic signed [DB_W-1:0] ratio_floor;
   logic signed [DB_W-1:0] ratio_ceiling;
   logic [FRAC_W-1:0]      bar_shown;

   meter_reading_type pending_readings [$];
   int                mismatches  = 0;
   int                idle_cycles = 0;
   bit                gaps_on     = 1'b1;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99, 0);
      if (!gaps_on || roll < 70) return 0;
      if (roll < 94) return $urandom_range(3, 1);
      return $urandom_range(60, 10);
   endfunction

   function automatic longint floor_quot(input longint num, input longint den);
      longint q;
      q = num / den;
      if ((num % den) != 0 && num < 0) q--;
      return q;
   endfunction

   function automatic int mark_level(input int i);
      return int'($signed(mark_word[i][31:16]));
   endfunction

   function automatic int mark_fraction(input int i);
      int f;
      f = int'(mark_word[i][15:0]);
      return (f > FULL_BAR) ? FULL_BAR : f;
   endfunction

   function automatic int active_marks();
      return (int'(mark_total) > NUM_MARKS) ? NUM_MARKS : int'(mark_total);
   endfunction

   function automatic int scale_position(input logic signed [DB_W-1:0] level);
      int n;
      int db;
      int lo_db;
      int hi_db;
      int lo_frac;
      int hi_frac;
      n  = active_marks();
      db = level;
      if (n < 2) begin
         if (int'(ratio_ceiling) <= int'(ratio_floor) || db <= int'(ratio_floor)) return 0;
         if (db >= int'(ratio_ceiling)) return FULL_BAR;
         return int'(floor_quot(longint'(db - int'(ratio_floor)) * FULL_BAR,
                                longint'(int'(ratio_ceiling) - int'(ratio_floor))));
      end
      if (db <= mark_level(0)) return mark_fraction(0);
      if (db >= mark_level(n - 1)) return mark_fraction(n - 1);
      // first segment whose upper mark reaches the reading wins
      for (int i = 1; i < n; i++) begin
         if (db <= mark_level(i)) begin
            lo_db   = mark_level(i - 1);
            hi_db   = mark_level(i);
            lo_frac = mark_fraction(i - 1);
            hi_frac = mark_fraction(i);
            return lo_frac + int'(floor_quot(longint'(db - lo_db) * longint'(hi_frac - lo_frac),
                                             longint'(hi_db - lo_db)));
         end
      end
      return mark_fraction(n - 1);
   endfunction

   function automatic void predict_meter(input logic signed [DB_W-1:0] level);
      int                target;
      int                shown;
      int                gap;
      meter_reading_type beat;
      target = scale_position(level);
      shown  = int'(bar_shown);
      if (target > shown) begin
         shown = target;
      end else if (target < shown) begin
         gap   = shown - target;
         shown = shown - (gap * FALL_NUM + FALL_DEN - 1) / FALL_DEN;
      end
      bar_shown   = shown[FRAC_W-1:0];
      beat.target = target[FRAC_W-1:0];
      beat.shown  = bar_shown;
      pending_readings.push_back(beat);
   endfunction

   function automatic void note_mismatch(input string field, input int want, input int got);
      if (mismatches < MAX_REPORTS)
         $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
      mismatches++;
   endfunction

   function automatic void check_reading(input logic [FRAC_W-1:0] got_target,
                                         input logic [FRAC_W-1:0] got_shown);
      meter_reading_type want;
      if (pending_readings.size() == 0) begin
         if (mismatches < MAX_REPORTS)
            $display("%0t: response beat with nothing expected, target %0d, shown %0d",
                     $realtime, got_target, got_shown);
         mismatches++;
         return;
      end
      want = pending_readings.pop_front();
      if (got_target !== want.target) note_mismatch("target_fraction", want.target, got_target);
      if (got_shown !== want.shown) note_mismatch("shown_fraction", want.shown, got_shown);
   endfunction

   function automatic logic [DB_W-1:0] any_level();
      logic [31:0] r;
      r = $urandom();
      return r[DB_W-1:0];
   endfunction

   function automatic logic [DB_W-1:0] level_between(input int lo, input int hi);
      int a;
      int b;
      a = (lo < -32768) ? -32768 : lo;
      b = (hi > 32767) ? 32767 : hi;
      if (b < a) b = a;
      a = a + int'($urandom_range(b - a, 0));
      return a[DB_W-1:0];
   endfunction

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_MARK_COUNT: mark_total = value[COUNT_W-1:0];
         CSR_MARK_ZERO, CSR_MARK_ONE, CSR_MARK_TWO, CSR_MARK_THREE, CSR_MARK_FOUR: begin
            mark_word[int'(idx) - int'(CSR_MARK_ZERO)] = value;
         end
         CSR_FLOOR_DB:   ratio_floor   = value[DB_W-1:0];
         CSR_CEILING_DB: ratio_ceiling = value[DB_W-1:0];
      endcase
   endtask

   task automatic write_mark(input int i, input int db, input int frac);
      csr_write(csr_index_type'(int'(CSR_MARK_ZERO) + i), {db[15:0], frac[15:0]});
   endtask

   // valid stays high between back-to-back beats
   task automatic send_level(input logic signed [DB_W-1:0] level);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.level_db <= level;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_meter(level);
   endtask

   // block is idle once every response is back
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic test_default_ratio();
      logic signed [DB_W-1:0] levels [$];
      levels = '{-16'sd32768, -16'sd15359, -16'sd7680, -16'sd7680, 16'sd0, 16'sd32767,
                 -16'sd32768, -16'sd32768, -16'sd20000};
      foreach (levels[i]) send_level(levels[i]);
   endtask

   task automatic test_scale_marks();
      settle();
      csr_write(CSR_MARK_COUNT, 32'd3);
      write_mark(0, -12288, 0);
      write_mark(1, -6144, 20000);
      write_mark(2, 0, 65535);      // oversized fraction reads as full
      send_level(-16'sd32768);
      send_level(-16'sd9000);
      send_level(-16'sd6144);
      send_level(-16'sd3000);
      send_level(16'sd32767);
      // count above the mark limit acts as five marks
      settle();
      write_mark(3, 6144, 30000);
      write_mark(4, 12288, 32768);
      csr_write(CSR_MARK_COUNT, 32'd7);
      send_level(16'sd9000);
      // marks with descending fractions, first mark level out of order
      settle();
      csr_write(CSR_MARK_ZERO, 32'hFFFF_FFFF);
      write_mark(1, -6144, 30000);
      write_mark(2, 6144, 5000);
      csr_write(CSR_MARK_COUNT, 32'd3);
      send_level(-16'sd3000);
      send_level(16'sd3000);
   endtask

   task automatic test_ratio_edges();
      settle();
      csr_write(CSR_MARK_COUNT, 32'd1);
      csr_write(CSR_FLOOR_DB, 32'h0000_8000);
      csr_write(CSR_CEILING_DB, 32'h0000_7FFF);
      send_level(-16'sd32767);
      send_level(16'sd32766);
      // empty range: equal, then reversed
      settle();
      csr_write(CSR_FLOOR_DB, 32'd5000);
      csr_write(CSR_CEILING_DB, 32'd5000);
      send_level(16'sd6000);
      settle();
      csr_write(CSR_CEILING_DB, 32'd1000);
      send_level(16'sd3000);
   endtask

   task automatic test_random_ratio();
      int lo;
      int hi;
      int swap;
      for (int phase = 0; phase < RATIO_PHASES; phase++) begin
         settle();
         gaps_on = ($urandom_range(3, 0) != 0);
         csr_write(CSR_MARK_COUNT, $urandom_range(1, 0));
         lo = int'($signed(any_level()));
         hi = int'($signed(any_level()));
         if (phase == 0) begin
            lo = -32768;
            hi = 32767;
         end else if ($urandom_range(99, 0) < 20) begin
            if ($urandom_range(1, 0) == 1) hi = lo;
            else if (lo < hi) begin
               swap = lo;
               lo   = hi;
               hi   = swap;
            end
         end else if (lo > hi) begin
            swap = lo;
            lo   = hi;
            hi   = swap;
         end
         csr_write(CSR_FLOOR_DB, lo);
         csr_write(CSR_CEILING_DB, hi);
         for (int k = 0; k < PHASE_BEATS; k++) begin
            if (lo < hi && $urandom_range(99, 0) < 75) send_level(level_between(lo - 512, hi + 512));
            else send_level(any_level());
         end
      end
   endtask

   task automatic test_random_marks();
      bit ordered;
      int db;
      int frac;
      int n;
      for (int phase = 0; phase < MARK_PHASES; phase++) begin
         settle();
         gaps_on = ($urandom_range(3, 0) != 0);
         ordered = ($urandom_range(99, 0) < 85);
         db = -32768 + int'($urandom_range(49152, 0));
         for (int i = 0; i < NUM_MARKS; i++) begin
            if (!ordered) begin
               csr_write(csr_index_type'(int'(CSR_MARK_ZERO) + i), $urandom());
            end else begin
               if (i > 0 && $urandom_range(9, 0) != 0) db = db + int'($urandom_range(6000, 1));
               if (db > 32767) db = 32767;
               if ($urandom_range(9, 0) == 0) frac = $urandom_range(65535, 32769);
               else frac = $urandom_range(32768, 0);
               write_mark(i, db, frac);
            end
         end
         csr_write(CSR_MARK_COUNT, $urandom_range(7, 2));
         n = active_marks();
         for (int k = 0; k < PHASE_BEATS; k++) begin
            if ($urandom_range(99, 0) < 80)
               send_level(level_between(mark_level(0) - 512, mark_level(n - 1) + 512));
            else
               send_level(any_level());
         end
      end
   endtask

   // response side: random stalls, checks every accepted beat
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            check_reading(rsp_bus.target_fraction, rsp_bus.shown_fraction);
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_index        <= CSR_MARK_COUNT;
      csr_wdata        <= '0;
      req_bus.valid    <= 1'b0;
      req_bus.level_db <= '0;
      mark_total    = '0;
      foreach (mark_word[i]) mark_word[i] = '0;
      ratio_floor   = FLOOR_RESET;
      ratio_ceiling = CEIL_RESET;
      bar_shown     = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_default_ratio();
      test_scale_marks();
      test_ratio_edges();
      test_random_ratio();
      test_random_marks();

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_readings.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
